### rtl/clcp_pkg.sv
// ----------------------------------------------------------------------------
// clcp_pkg
// Shared types, codes and constants of the circular log command planner.
// ----------------------------------------------------------------------------
package clcp_pkg;

   // Fixed geometry of the logs
   localparam int unsigned ENTRY_BYTES  = 16;
   localparam int unsigned ENTRY_SHIFT  = $clog2(ENTRY_BYTES);
   localparam int unsigned SECTOR_SPAN  = 4096;
   localparam int unsigned KEEP_ENTRIES = 512;
   localparam int unsigned REGION_COUNT = 4;
   localparam int unsigned MAX_RESULTS  = 4;

   // Entry counts and positions: a region spans at most 2^24 bytes
   localparam int unsigned ENT_W = 25 - ENTRY_SHIFT;

   localparam logic [ENT_W-1:0] SPAN_POS      = ENT_W'(SECTOR_SPAN);
   localparam logic [ENT_W-1:0] KEEP_POS      = ENT_W'(KEEP_ENTRIES);
   localparam logic [ENT_W-1:0] KEEP_HIGH_POS = ENT_W'(KEEP_ENTRIES + SECTOR_SPAN);
   localparam logic [23:0]      SPAN_ADDR     = 24'(SECTOR_SPAN);

   // Configuration register file
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_W     = 24;

   // Request kinds
   localparam logic [1:0] MODE_STORE = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   // Command codes
   localparam logic [2:0] CMD_WRITE        = 3'd0;
   localparam logic [2:0] CMD_READ         = 3'd1;
   localparam logic [2:0] CMD_ERASE_SECTOR = 3'd2;
   localparam logic [2:0] CMD_ERASE_CHIP   = 3'd3;
   localparam logic [2:0] CMD_REJECT       = 3'd4;

   typedef logic [23:0] addr_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [1:0]  log_select;
      logic [15:0] entry_count;
      logic [15:0] entry_offset;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [23:0] address;
      logic [23:0] byte_count;
      logic        last;
   } rsp_word_type;

   // Planned commands of one request, handed to the result queue
   typedef struct packed {
      rsp_word_type [MAX_RESULTS-1:0] word;
      logic [2:0]                     count;
   } plan_type;

   // Entries to bytes, wrapped to 24 bits
   function automatic logic [23:0] to_bytes(input logic [ENT_W:0] entries);
      logic [ENT_W+ENTRY_SHIFT:0] wide;
      wide = {entries, {ENTRY_SHIFT{1'b0}}};
      return wide[23:0];
   endfunction

   function automatic rsp_word_type make_word(input logic [2:0]  command,
                                              input logic [23:0] address,
                                              input logic [23:0] byte_count);
      rsp_word_type w;
      w.command    = command;
      w.address    = address;
      w.byte_count = byte_count;
      w.last       = 1'b0;
      return w;
   endfunction

endpackage

### rtl/clcp_planner.sv
// ----------------------------------------------------------------------------
// clcp_planner
// Turns one registered request into its list of flash commands and keeps the
// per-log write position and half-erased flags.
// ----------------------------------------------------------------------------
module clcp_planner #(
   parameter int LOG_COUNT = 4
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               fire,
   input  clcp_pkg::req_word_type                             req_word,
   input  clcp_pkg::addr_type [clcp_pkg::REGION_COUNT-1:0]    region_start,
   input  clcp_pkg::addr_type [clcp_pkg::REGION_COUNT-1:0]    region_stop,
   output clcp_pkg::plan_type                                 plan
);
   import clcp_pkg::*;

   localparam int LOG_IDX_W = (LOG_COUNT > 1) ? $clog2(LOG_COUNT) : 1;

   // Per-log state
   logic [ENT_W-1:0]     pos_ff  [LOG_COUNT];
   logic [LOG_COUNT-1:0] low_erased_ff;
   logic [LOG_COUNT-1:0] high_erased_ff;

   logic [LOG_IDX_W-1:0] lg_idx;
   logic                 lg_ok;
   addr_type             start_sel;
   addr_type             stop_sel;
   addr_type             top_addr;
   logic [24:0]          span;
   logic [ENT_W-1:0]     entries;
   logic [ENT_W-1:0]     pos_raw;
   logic [ENT_W-1:0]     pos;
   logic [ENT_W:0]       pos_x;
   logic [ENT_W:0]       entries_x;
   logic [ENT_W:0]       cnt_x;
   logic [ENT_W:0]       off_x;
   logic [ENT_W:0]       sum;
   logic [ENT_W:0]       first;
   logic [ENT_W:0]       rest;
   logic [ENT_W-1:0]     next_pos;
   logic [ENT_W:0]       span_end;
   logic [ENT_W:0]       back;
   logic                 is_store;
   logic                 is_read;
   logic                 rejected;
   logic                 low_cur;
   logic                 high_cur;
   logic                 erase_low;
   logic                 erase_high;
   logic                 store_go;
   rsp_word_type [MAX_RESULTS-1:0] words;
   logic [2:0]           k;

   // Select the log and its region
   assign lg_idx    = req_word.log_select[LOG_IDX_W-1:0];
   assign lg_ok     = (LOG_COUNT >= 4) || (int'(req_word.log_select) < LOG_COUNT);
   assign start_sel = region_start[req_word.log_select];
   assign stop_sel  = region_stop[req_word.log_select];
   assign top_addr  = stop_sel + 24'd1;
   assign span      = {1'b0, stop_sel} + 25'd1 - {1'b0, start_sel};
   assign entries   = (stop_sel < start_sel) ? '0 : span[24:ENTRY_SHIFT];

   // Take a stale position as zero
   assign pos_raw = lg_ok ? pos_ff[lg_idx] : '0;
   assign pos     = (pos_raw >= entries) ? '0 : pos_raw;

   assign pos_x     = (ENT_W+1)'(pos);
   assign entries_x = (ENT_W+1)'(entries);
   assign cnt_x     = (ENT_W+1)'(req_word.entry_count);
   assign off_x     = (ENT_W+1)'(req_word.entry_offset);

   // Store arithmetic
   assign sum      = pos_x + cnt_x;
   assign first    = entries_x - pos_x;
   assign rest     = sum - entries_x;
   assign next_pos = (sum >= entries_x) ? rest[ENT_W-1:0] : sum[ENT_W-1:0];

   // Read arithmetic
   assign span_end = off_x + cnt_x;
   assign back     = span_end - pos_x;

   assign is_store = (req_word.mode == MODE_STORE);
   assign is_read  = (req_word.mode == MODE_READ);
   assign rejected = !(is_store || is_read) || !lg_ok || (entries == '0) ||
                     (req_word.entry_count == 16'd0) ||
                     (is_store && (cnt_x > entries_x)) ||
                     (is_read && (span_end > entries_x));

   // Half-erased flags after this store's write
   assign low_cur    = (pos < SPAN_POS) ? 1'b0 : low_erased_ff[lg_idx];
   assign high_cur   = (pos < SPAN_POS) ? high_erased_ff[lg_idx] : 1'b0;
   assign erase_low  = !low_cur && (next_pos > KEEP_POS);
   assign erase_high = !high_cur && (next_pos > KEEP_HIGH_POS);
   assign store_go   = fire && is_store && !rejected;

   // Build the command list in emission order
   always_comb begin
      words = '0;
      k     = 3'd0;
      if (req_word.mode == MODE_CLEAR) begin
         words[0] = make_word(CMD_ERASE_CHIP, '0, '0);
         k        = 3'd1;
      end else if (rejected) begin
         words[0] = make_word(CMD_REJECT, '0, '0);
         k        = 3'd1;
      end else if (is_store) begin
         if (sum > entries_x) begin
            words[0] = make_word(CMD_WRITE, start_sel + to_bytes(pos_x), to_bytes(first));
            words[1] = make_word(CMD_WRITE, start_sel, to_bytes(rest));
            k        = 3'd2;
         end else begin
            words[0] = make_word(CMD_WRITE, start_sel + to_bytes(pos_x), to_bytes(cnt_x));
            k        = 3'd1;
         end
         if (erase_low) begin
            words[k[1:0]] = make_word(CMD_ERASE_SECTOR, start_sel, '0);
            k             = k + 3'd1;
         end
         if (erase_high) begin
            words[k[1:0]] = make_word(CMD_ERASE_SECTOR, start_sel + SPAN_ADDR, '0);
            k             = k + 3'd1;
         end
      end else begin
         if (span_end <= pos_x) begin
            words[0] = make_word(CMD_READ, start_sel + to_bytes(pos_x - span_end),
                                 to_bytes(cnt_x));
            k        = 3'd1;
         end else if (off_x < pos_x) begin
            words[0] = make_word(CMD_READ, top_addr - to_bytes(back), to_bytes(back));
            words[1] = make_word(CMD_READ, start_sel, to_bytes(pos_x - off_x));
            k        = 3'd2;
         end else begin
            words[0] = make_word(CMD_READ, top_addr - to_bytes(back), to_bytes(cnt_x));
            k        = 3'd1;
         end
      end
      words[2'(k - 3'd1)].last = 1'b1;
   end

   assign plan.word  = words;
   assign plan.count = k;

   // Update log state when the plan is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LOG_COUNT; i++) begin
            pos_ff[i] <= '0;
         end
         low_erased_ff  <= '1;
         high_erased_ff <= '1;
      end else if (fire && (req_word.mode == MODE_CLEAR)) begin
         low_erased_ff  <= '1;
         high_erased_ff <= '1;
      end else if (store_go) begin
         pos_ff[lg_idx]         <= next_pos;
         low_erased_ff[lg_idx]  <= low_cur || erase_low;
         high_erased_ff[lg_idx] <= high_cur || erase_high;
      end
   end

endmodule

### rtl/clcp_rsp_queue.sv
// ----------------------------------------------------------------------------
// clcp_rsp_queue
// Holds the commands of one planned request and hands them out one word per
// cycle while rsp_stall is low, oldest first.
// ----------------------------------------------------------------------------
module clcp_rsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  clcp_pkg::plan_type      plan,
   output logic                    plan_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output clcp_pkg::rsp_word_type  rsp_word
);
   import clcp_pkg::*;

   rsp_word_type words_ff [MAX_RESULTS];
   rsp_word_type words_in [MAX_RESULTS];
   logic [2:0]   count_ff;
   logic [2:0]   count_in;
   logic         pop;

   assign rsp_valid  = (count_ff != 3'd0);
   assign rsp_word   = words_ff[0];
   assign pop        = rsp_valid && !rsp_stall;
   // Take a new plan once the last held word leaves
   assign plan_ready = (count_ff == 3'd0) || ((count_ff == 3'd1) && pop);

   // Load a plan or shift the queue down on a pop
   always_comb begin
      words_in = words_ff;
      count_in = count_ff;
      if (load) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            words_in[i] = plan.word[i];
         end
         count_in = plan.count;
      end else if (pop) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            words_in[i] = words_ff[i+1];
         end
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      words_ff <= words_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

### rtl/circular_log_command_planner.sv
// ----------------------------------------------------------------------------
// circular_log_command_planner
// Plans flash write, read and erase commands for circular logs.
// ----------------------------------------------------------------------------
// Usage:
//   Request words enter on req_valid/req_stall: store entries, read entries
//   or clear all logs. Each request yields one to four command words on
//   rsp_valid/rsp_stall; the final word of a request carries last.
//   Log regions are set through csr_write_enable/csr_index/csr_data while no
//   request is in flight (even index: first byte, odd index: last byte).
//   Path: a request is held in the input register, is planned in one pass
//   into the result queue, and its first word shows in the cycle after.
//   Throughput: one command word per cycle on the result side while
//   rsp_stall is low. The next request is taken into the input register
//   while the queue drains and is planned on the cycle its predecessor's
//   last word leaves.
//   Reset clears the region registers, write positions and queue, and marks
//   every log half as erased. A stalled receiver holds the current word; the
//   input stalls once the input register is full and the queue is busy.
// ----------------------------------------------------------------------------
module circular_log_command_planner #(
   parameter int LOG_COUNT = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  clcp_pkg::req_word_type              req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output clcp_pkg::rsp_word_type              rsp_word,
   input  logic                                csr_write_enable,
   input  logic [clcp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [clcp_pkg::CSR_W-1:0]          csr_data
);
   import clcp_pkg::*;

   addr_type [REGION_COUNT-1:0] start_ff;
   addr_type [REGION_COUNT-1:0] stop_ff;
   req_word_type                req_word_ff;
   logic                        req_valid_ff;
   logic                        plan_ready;
   logic                        plan_fire;
   plan_type                    plan;

   // Region registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         stop_ff  <= '0;
      end else if (csr_write_enable) begin
         if (csr_index[0]) begin
            stop_ff[csr_index[CSR_IDX_W-1:1]] <= csr_data;
         end else begin
            start_ff[csr_index[CSR_IDX_W-1:1]] <= csr_data;
         end
      end
   end

   // Input register: refill as soon as the held request is planned
   assign plan_fire = req_valid_ff && plan_ready;
   assign req_stall = req_valid_ff && !plan_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         req_valid_ff <= 1'b1;
      end else if (plan_fire) begin
         req_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_word_ff <= req_word;
      end
   end

   clcp_planner #(
      .LOG_COUNT (LOG_COUNT)
   ) u_planner (
      .clock        (clock),
      .reset        (reset),
      .fire         (plan_fire),
      .req_word     (req_word_ff),
      .region_start (start_ff),
      .region_stop  (stop_ff),
      .plan         (plan)
   );

   clcp_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .load       (plan_fire),
      .plan       (plan),
      .plan_ready (plan_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word)
   );

`ifndef SYNTHESIS
   // A plan always holds between one and four commands
   assert property (@(posedge clock) disable iff (reset)
      plan_fire |-> (plan.count != 3'd0) && (plan.count <= 3'd4))
      else $error("plan command count out of range");

   // The queue holds exactly the planned commands after a load
   assert property (@(posedge clock) disable iff (reset)
      plan_fire |=> (u_rsp_queue.count_ff == $past(plan.count)))
      else $error("queue count does not match plan");

   // last marks exactly the final queued word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.last == (u_rsp_queue.count_ff == 3'd1)))
      else $error("last flag out of place");
`endif

endmodule
